### rtl/htfd_pkg.sv
// Shared types, constants and the CRC-8 byte step for the humidity and
// temperature frame decoder. No dependencies.
`default_nettype none

package htfd_pkg;

    // Result error codes
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_CRC  = 2'd1;
    localparam logic [1:0] ERR_NACK = 2'd2;

    // Sensor families
    localparam logic FAM_SINGLE = 1'b0;
    localparam logic FAM_DUAL   = 1'b1;

    // Frame lengths as final byte index
    localparam logic [2:0] LAST_SINGLE = 3'd2;
    localparam logic [2:0] LAST_DUAL   = 3'd5;

    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] STATUS_MASK = 8'hFC;

    // Conversion gains and offsets, hundredths
    localparam logic [14:0] T_MUL_SINGLE = 15'd17572;
    localparam logic [14:0] T_MUL_DUAL   = 15'd17500;
    localparam logic [13:0] H_MUL_SINGLE = 14'd12500;
    localparam logic [13:0] H_MUL_DUAL   = 14'd10000;
    localparam logic [12:0] T_OFF_SINGLE = 13'd4685;
    localparam logic [12:0] T_OFF_DUAL   = 13'd4500;
    localparam logic [13:0] H_OFF_SINGLE = 14'd600;
    localparam logic [13:0] H_OFF_DUAL   = 14'd0;
    localparam logic [13:0] H_MAX        = 14'd10000;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       quantity_is_humidity;
        logic       bus_nack;
    } t_htfd_in;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic               temp_valid;
        logic               humid_valid;
        logic [1:0]         error_code;
    } t_htfd_out;

    typedef enum logic [1:0] {
        TOK_CONV = 2'd0,
        TOK_CRC  = 2'd1,
        TOK_NACK = 2'd2
    } t_tok_kind;

    // Completed frame, ready for scaling
    typedef struct packed {
        t_tok_kind   kind;
        logic        family;
        logic        qty;
        logic [15:0] traw;
        logic [15:0] hraw;
    } t_htfd_tok;

    // Scaled products, ready for division and offset
    typedef struct packed {
        t_tok_kind   kind;
        logic        family;
        logic        qty;
        logic [30:0] tprod;
        logic [29:0] hprod;
    } t_htfd_prod;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/htfd_frame.sv
// Byte counting, running CRC and frame byte storage.
// Emits one token per result-producing byte. Depends on htfd_pkg.
`default_nettype none

module htfd_frame
    import htfd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_htfd_in  i_in,
    input  wire logic      i_family,
    output logic           o_tok_valid,
    output t_htfd_tok      o_tok
);

    logic [2:0] r_idx, n_idx;
    logic [7:0] r_crc, n_crc;
    logic       r_qty, n_qty;
    logic [7:0] r_b0, r_b1, r_b3, r_b4;

    logic [2:0] idx0;
    logic [7:0] crc0;
    logic [2:0] last;
    logic       qty0;

    assign idx0 = i_in.frame_start ? 3'd0 : r_idx;
    assign crc0 = i_in.frame_start ? 8'd0 : r_crc;
    assign qty0 = (idx0 == 3'd0) ? i_in.quantity_is_humidity : r_qty;
    assign last = (i_family == FAM_DUAL) ? LAST_DUAL : LAST_SINGLE;

    always_comb begin
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_qty       = r_qty;
        o_tok_valid = 1'b0;
        o_tok.kind   = TOK_CONV;
        o_tok.family = i_family;
        o_tok.qty    = qty0;
        if (i_family == FAM_DUAL) begin
            o_tok.traw = {r_b0, r_b1};
            o_tok.hraw = {r_b3, r_b4};
        end else begin
            o_tok.traw = {r_b0, r_b1 & STATUS_MASK};
            o_tok.hraw = {r_b0, r_b1 & STATUS_MASK};
        end
        if (i_accept) begin
            priority if (i_in.bus_nack) begin
                n_idx       = 3'd0;
                n_crc       = 8'd0;
                o_tok_valid = 1'b1;
                o_tok.kind  = TOK_NACK;
            end else if (idx0 < last) begin
                n_qty = qty0;
                n_idx = idx0 + 3'd1;
                n_crc = (idx0 < 3'd2) ? crc8_byte(crc0, i_in.rx_byte) : crc0;
            end else begin
                n_qty       = qty0;
                n_idx       = 3'd0;
                n_crc       = 8'd0;
                o_tok_valid = 1'b1;
                if (i_family == FAM_SINGLE && crc0 != i_in.rx_byte) begin
                    o_tok.kind = TOK_CRC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_crc <= 8'd0;
            r_qty <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
            r_qty <= n_qty;
        end
    end

    // Frame bytes: byte 2 is a CRC byte, checked on arrival in single frames but not kept
    always_ff @(posedge i_clk) begin
        if (i_accept && !i_in.bus_nack && idx0 < last) begin
            if (idx0 == 3'd0) r_b0 <= i_in.rx_byte;
            if (idx0 == 3'd1) r_b1 <= i_in.rx_byte;
            if (idx0 == 3'd3) r_b3 <= i_in.rx_byte;
            if (idx0 == 3'd4) r_b4 <= i_in.rx_byte;
        end
    end

endmodule

`default_nettype wire

### rtl/htfd_conv.sv
// Division, offset and saturation of the scaled raw values into hundredths.
// Combinational; depends on htfd_pkg.
`default_nettype none

module htfd_conv
    import htfd_pkg::*;
(
    input  wire t_htfd_prod i_prod,
    output t_htfd_out       o_res
);

    logic [31:0] t_sum;
    logic [14:0] t_q;
    logic [15:0] t_r;
    logic        t_nz;
    logic [12:0] t_off;
    logic [15:0] t_val;
    logic [31:0] h_sum;
    logic [13:0] h_q;
    logic [13:0] h_off;
    logic [13:0] h_d;
    logic [13:0] h_val;
    logic        tv, hv;

    // Exact floor(x / 65535) for x below 2^32 - 1: (x + (x >> 16) + 1) >> 16
    assign t_sum = {1'b0, i_prod.tprod} + {17'd0, i_prod.tprod[30:16]} + 32'd1;
    assign h_sum = {2'b0, i_prod.hprod} + {18'd0, i_prod.hprod[29:16]} + 32'd1;

    always_comb begin
        if (i_prod.family == FAM_DUAL) begin
            t_q   = t_sum[30:16];
            // remainder is below 2^16, so its low half is exact
            t_r   = i_prod.tprod[15:0] + {1'b0, t_q};
            t_nz  = (t_r != 16'd0);
            t_off = T_OFF_DUAL;
            h_q   = h_sum[29:16];
            h_off = H_OFF_DUAL;
        end else begin
            t_q   = i_prod.tprod[30:16];
            t_r   = i_prod.tprod[15:0];
            t_nz  = (t_r != 16'd0);
            t_off = T_OFF_SINGLE;
            h_q   = i_prod.hprod[29:16];
            h_off = H_OFF_SINGLE;
        end
        // truncate toward zero: round a negative fractional result up
        t_val = {1'b0, t_q} - {3'b0, t_off}
              + {15'd0, (t_nz && (t_q < {2'b0, t_off}))};
        h_d   = h_q - h_off;
        if (h_q < h_off) begin
            h_val = 14'd0;
        end else if (h_d > H_MAX) begin
            h_val = H_MAX;
        end else begin
            h_val = h_d;
        end
    end

    assign tv = (i_prod.kind == TOK_CONV) && (i_prod.family == FAM_DUAL || !i_prod.qty);
    assign hv = (i_prod.kind == TOK_CONV) && (i_prod.family == FAM_DUAL || i_prod.qty);

    always_comb begin
        o_res.temperature_centi = tv ? t_val[14:0] : 15'sd0;
        o_res.humidity_centi    = hv ? h_val : 14'd0;
        o_res.temp_valid        = tv;
        o_res.humid_valid       = hv;
        unique case (i_prod.kind)
            TOK_CONV: o_res.error_code = ERR_OK;
            TOK_CRC:  o_res.error_code = ERR_CRC;
            TOK_NACK: o_res.error_code = ERR_NACK;
            default:  o_res.error_code = ERR_OK;
        endcase
    end

endmodule

`default_nettype wire

### rtl/humidity_temp_frame_decoder_core.sv
// Humidity and temperature frame decoder: byte-wise frame assembly with CRC-8
// check of single-quantity frames, and fixed-point conversion to hundredths.
// Depends on htfd_pkg, htfd_frame and htfd_conv.
// Throughput: one byte per cycle, sustained, with the result side ready.
// Pipeline: the result for a frame's final byte or a NACK byte is registered
//   through the frame stage, multiply stage and divide/output stage in turn.
// Reset (i_rst_n low, synchronous): clears the byte count, CRC, family
//   register and all stage valids; stored frame bytes are not cleared.
`default_nettype none

module humidity_temp_frame_decoder_core
    import htfd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // configuration: sensor family
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_data,
    output logic           o_cfg_ready,
    // byte input
    input  wire logic      i_in_valid,
    input  wire t_htfd_in  i_in_data,
    output logic           o_in_ready,
    // result output
    output logic           o_out_valid,
    output t_htfd_out      o_out_data,
    input  wire logic      i_out_ready
);

    logic       r_family;
    logic       in_xfer;

    logic       tok_valid;
    t_htfd_tok  tok;

    logic       r_s1_valid;
    t_htfd_tok  r_s1;
    logic       r_s2_valid;
    t_htfd_prod r_s2;
    logic       r_out_valid;
    t_htfd_out  r_out;

    t_htfd_prod n_s2;
    t_htfd_out  n_out;

    logic       out_adv, s2_adv, s1_adv;

    // Configuration is always taken; the block is idle by contract
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family <= FAM_SINGLE;
        end else if (i_cfg_valid) begin
            r_family <= i_cfg_data;
        end
    end

    // Each stage advances when its downstream slot is empty or moving on,
    // so bubbles collapse and the input keeps flowing while a result waits.
    assign out_adv    = !r_out_valid || i_out_ready;
    assign s2_adv     = !r_s2_valid || out_adv;
    assign s1_adv     = !r_s1_valid || s2_adv;
    assign o_in_ready = s1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Frame stage: count bytes, run the CRC, emit a token on frame end or NACK
    htfd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_in        (i_in_data),
        .i_family    (r_family),
        .o_tok_valid (tok_valid),
        .o_tok       (tok)
    );

    // Multiply stage: scale raw values by the family's gain
    always_comb begin
        n_s2.kind   = r_s1.kind;
        n_s2.family = r_s1.family;
        n_s2.qty    = r_s1.qty;
        n_s2.tprod  = 31'((r_s1.family == FAM_DUAL) ? T_MUL_DUAL : T_MUL_SINGLE)
                    * 31'(r_s1.traw);
        n_s2.hprod  = 30'((r_s1.family == FAM_DUAL) ? H_MUL_DUAL : H_MUL_SINGLE)
                    * 30'(r_s1.hraw);
    end

    // Divide, offset and saturate
    htfd_conv u_conv (
        .i_prod (r_s2),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv)  r_s1_valid  <= in_xfer && tok_valid;
            if (s2_adv)  r_s2_valid  <= r_s1_valid;
            if (out_adv) r_out_valid <= r_s2_valid;
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (s1_adv)  r_s1  <= tok;
        if (s2_adv)  r_s2  <= n_s2;
        if (out_adv) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A NACK transfer always yields a token in the frame stage next cycle
    a_nack_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.bus_nack) |=> (r_s1_valid && r_s1.kind == TOK_NACK))
        else $error("NACK transfer produced no abort token");

    // An error result never carries a converted value
    a_err_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code != ERR_OK)
            |-> (!o_out_data.temp_valid && !o_out_data.humid_valid))
        else $error("error result flagged a valid value");

    // Humidity stays saturated
    a_humid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.humidity_centi <= H_MAX))
        else $error("humidity above full scale");

    // A successful result carries at least one value
    a_ok_has_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code == ERR_OK)
            |-> (o_out_data.temp_valid || o_out_data.humid_valid))
        else $error("ok result without a value");

endmodule

`default_nettype wire

### tb/humidity_temp_frame_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for humidity_temp_frame_decoder_core: directed and random
// byte streams with randomized handshake idling, checked against a cycle-free frame
// decoder. Depends on htfd_pkg and the core RTL.

module humidity_temp_frame_decoder_core_tb;
    import htfd_pkg::*;

    localparam int TOTAL_BYTES    = 1050;
    localparam int QUIET_FROM     = TOTAL_BYTES - 150;
    localparam int PHASE_BYTES    = 120;
    localparam int DRAIN_CYCLES   = 6;     // pipeline depth is 3, keep some margin
    localparam int WATCHDOG_LIMIT = 1000;

    // Decoded-reading tracker: mirrors the frame assembly and the conversions,
    // and holds the readings still owed by the block, oldest first.
    class reading_tracker;
        logic       family;
        logic [2:0] byte_pos;
        logic [7:0] crc_acc;
        logic [7:0] held [5];
        logic       want_humidity;
        t_htfd_out  pending [$];

        function new();
            family        = FAM_SINGLE;
            byte_pos      = '0;
            crc_acc       = '0;
            want_humidity = 1'b0;
            foreach (held[i]) held[i] = '0;
        endfunction

        // Feed one byte MSB first through the 0x31 polynomial
        function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            logic       fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0};
                if (fb) c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        // offset + gain*raw/den in hundredths, truncated toward zero
        function longint centi(longint offset, longint gain, longint den, logic [15:0] raw);
            longint n;
            n = offset * den + gain * longint'(raw);
            return n / den;
        endfunction

        function longint clamp_rh(longint h);
            if (h < 0) return 0;
            if (h > 10000) return 10000;
            return h;
        endfunction

        function void take_byte(t_htfd_in it);
            logic [2:0] final_pos;
            logic [15:0] raw_t;
            logic [15:0] raw_h;
            t_htfd_out  r;
            final_pos = (family == FAM_DUAL) ? 3'd5 : 3'd2;
            r = '0;
            if (it.bus_nack) begin
                byte_pos     = '0;
                crc_acc      = '0;
                r.error_code = ERR_NACK;
                pending.push_back(r);
                return;
            end
            if (it.frame_start) begin
                byte_pos = '0;
                crc_acc  = '0;
            end
            if (byte_pos == 3'd0) want_humidity = it.quantity_is_humidity;
            if (byte_pos < final_pos) begin
                held[byte_pos] = it.rx_byte;
                if (byte_pos < 3'd2) crc_acc = crc_step(crc_acc, it.rx_byte);
                byte_pos = byte_pos + 3'd1;
                return;
            end
            if (family == FAM_SINGLE) begin
                if (crc_acc != it.rx_byte) begin
                    r.error_code = ERR_CRC;
                end else begin
                    raw_t = {held[0], held[1][7:2], 2'b00};
                    if (want_humidity) begin
                        r.humidity_centi = 14'(clamp_rh(centi(-600, 12500, 65536, raw_t)));
                        r.humid_valid    = 1'b1;
                    end else begin
                        r.temperature_centi = 15'(centi(-4685, 17572, 65536, raw_t));
                        r.temp_valid        = 1'b1;
                    end
                end
            end else begin
                raw_t = {held[0], held[1]};
                raw_h = {held[3], held[4]};
                r.temperature_centi = 15'(centi(-4500, 17500, 65535, raw_t));
                r.humidity_centi    = 14'(clamp_rh(centi(0, 10000, 65535, raw_h)));
                r.temp_valid        = 1'b1;
                r.humid_valid       = 1'b1;
            end
            byte_pos = '0;
            crc_acc  = '0;
            pending.push_back(r);
        endfunction

        // Empty string when the reading matches the oldest one owed
        function string match_reading(t_htfd_out got);
            t_htfd_out want;
            string     msg;
            if (pending.size() == 0)
                return $sformatf("unexpected reading t=%0d rh=%0d tv=%b hv=%b err=%0d",
                                 got.temperature_centi, got.humidity_centi,
                                 got.temp_valid, got.humid_valid, got.error_code);
            want = pending.pop_front();
            msg  = "";
            if (got.temperature_centi !== want.temperature_centi)
                msg = {msg, $sformatf(" temperature_centi %0d want %0d",
                                      got.temperature_centi, want.temperature_centi)};
            if (got.humidity_centi !== want.humidity_centi)
                msg = {msg, $sformatf(" humidity_centi %0d want %0d",
                                      got.humidity_centi, want.humidity_centi)};
            if (got.temp_valid !== want.temp_valid)
                msg = {msg, $sformatf(" temp_valid %b want %b",
                                      got.temp_valid, want.temp_valid)};
            if (got.humid_valid !== want.humid_valid)
                msg = {msg, $sformatf(" humid_valid %b want %b",
                                      got.humid_valid, want.humid_valid)};
            if (got.error_code !== want.error_code)
                msg = {msg, $sformatf(" error_code %0d want %0d",
                                      got.error_code, want.error_code)};
            return msg;
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      o_cfg_ready;
    logic      i_in_valid  = 1'b0;
    t_htfd_in  i_in_data   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_htfd_out o_out_data;
    logic      i_out_ready = 1'b0;

    reading_tracker tracker;
    int  mismatch_count = 0;
    int  bytes_sent     = 0;
    int  quiet_cycles   = 0;
    int  gap_odds       = 4;     // 1 in N bytes is preceded by a gap; 0 = never
    int  stall_odds     = 5;     // 1 in N draws opens a receiver stall; 0 = never
    int  stall_left     = 0;
    logic cur_family    = FAM_SINGLE;

    humidity_temp_frame_decoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns:%s", $time, msg);
    endtask

    // Sample every channel at the edge, before any driver update lands.
    // Check results before noting inputs so the queue order never depends on
    // process scheduling. The watchdog also lives here.
    always @(posedge i_clk) begin : monitor
        string verdict;
        logic  moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && i_out_ready) begin
                verdict = tracker.match_reading(o_out_data);
                if (verdict != "") report_mismatch(verdict);
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                tracker.take_byte(i_in_data);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.family = i_cfg_data;
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("humidity_temp_frame_decoder_core test failed");
                $finish;
            end
        end
    end

    // Receiver side: open stall bursts at the current odds, counted down in stall_left
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Present one byte and hold it until the transfer. Valid stays high when
    // the next byte follows without a gap.
    task automatic send_byte(input logic [7:0] b, input logic st, input logic q,
                             input logic nk);
        t_htfd_in item;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        item.rx_byte              = b;
        item.frame_start          = st;
        item.quantity_is_humidity = q;
        item.bus_nack             = nk;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // Drop valid and hold until every owed reading is out, then let the
    // pipeline settle in case a byte in flight was mid-frame.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_family(input logic f);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= f;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_family = f;
    endtask

    // Three-byte frame; corrupt the check byte when crc_ok is low
    task automatic send_single(input logic [15:0] raw, input logic q, input logic st,
                               input logic crc_ok);
        logic [7:0] crc;
        crc = tracker.crc_step(tracker.crc_step(8'h00, raw[15:8]), raw[7:0]);
        if (!crc_ok) crc = crc ^ 8'($urandom_range(1, 255));
        send_byte(raw[15:8], st, q, 1'b0);
        send_byte(raw[7:0], 1'b0, 1'($urandom), 1'b0);
        send_byte(crc, 1'b0, 1'($urandom), 1'b0);
    endtask

    // Six-byte frame; its check bytes are not examined, so fill them at random
    task automatic send_dual(input logic [15:0] traw, input logic [15:0] hraw,
                             input logic st);
        send_byte(traw[15:8], st, 1'($urandom), 1'b0);
        send_byte(traw[7:0], 1'b0, 1'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0, 1'($urandom), 1'b0);
        send_byte(hraw[15:8], 1'b0, 1'($urandom), 1'b0);
        send_byte(hraw[7:0], 1'b0, 1'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0, 1'($urandom), 1'b0);
    endtask

    // Raw values biased toward the ends and the low humidity clamp edge
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(3000, 3300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_directed();
        logic [7:0] b0;
        logic [7:0] b1;
        // Single-quantity frames at the raw extremes, both quantities
        send_single(16'hFFFF, 1'b0, 1'b1, 1'b1);
        send_single(16'h0000, 1'b1, 1'b1, 1'b1);
        send_single(16'hFFFF, 1'b1, 1'b1, 1'b1);
        // Bad check byte, and no start flag: the previous frame just ended
        send_single(16'h1234, 1'b0, 1'b0, 1'b0);
        // Abort mid-frame, then a NACK with no frame open
        send_byte(8'h66, 1'b1, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b1, 1'b1);
        send_byte(8'h5A, 1'b1, 1'b0, 1'b1);
        // Restart a frame after its first byte
        b0 = 8'h80;
        b1 = 8'h03;
        send_byte(8'hC3, 1'b1, 1'b0, 1'b0);
        send_byte(b0, 1'b1, 1'b1, 1'b0);
        send_byte(b1, 1'b0, 1'b0, 1'b0);
        send_byte(tracker.crc_step(tracker.crc_step(8'h00, b0), b1), 1'b0, 1'b0, 1'b0);

        wait_drained();
        write_family(FAM_DUAL);
        send_dual(16'h0000, 16'hFFFF, 1'b1);
        send_dual(16'hFFFF, 16'h0000, 1'b0);
        // Leave a dual frame three bytes in, then switch families under it:
        // the next byte closes the frame as a checked single-quantity one
        b0 = 8'h4E;
        b1 = 8'h9B;
        send_byte(b0, 1'b1, 1'b1, 1'b0);
        send_byte(b1, 1'b0, 1'b0, 1'b0);
        send_byte(8'h17, 1'b0, 1'b0, 1'b0);
        wait_drained();
        write_family(FAM_SINGLE);
        send_byte(tracker.crc_step(tracker.crc_step(8'h00, b0), b1), 1'b0, 1'b0, 1'b0);
    endtask

    task automatic run_random();
        int next_phase;
        int choice;
        int cut;
        next_phase = bytes_sent + PHASE_BYTES;
        while (bytes_sent < TOTAL_BYTES) begin
            if (bytes_sent >= next_phase) begin
                // Drain, retune the idling, and usually flip the family
                wait_drained();
                write_family(($urandom_range(0, 3) == 0) ? cur_family : ~cur_family);
                case ($urandom_range(0, 2))
                    0:       begin gap_odds = 0; stall_odds = 0; end
                    1:       begin gap_odds = 3; stall_odds = 4; end
                    default: begin gap_odds = 8; stall_odds = 10; end
                endcase
                next_phase = bytes_sent + PHASE_BYTES;
            end
            if (bytes_sent >= QUIET_FROM) begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            choice = $urandom_range(0, 99);
            if (choice < 65) begin
                if (cur_family == FAM_SINGLE)
                    send_single(pick_raw(), 1'($urandom), $urandom_range(0, 3) != 0, 1'b1);
                else
                    send_dual(pick_raw(), pick_raw(), $urandom_range(0, 3) != 0);
            end else if (choice < 75) begin
                if (cur_family == FAM_SINGLE)
                    send_single(16'($urandom), 1'($urandom), 1'b1, 1'b0);
                else
                    send_dual(16'($urandom), 16'($urandom), 1'b1);
            end else if (choice < 85) begin
                // Truncated frame, left open for whatever comes next
                cut = $urandom_range(1, (cur_family == FAM_DUAL) ? 5 : 2);
                send_byte(8'($urandom), 1'b1, 1'($urandom), 1'b0);
                for (int i = 1; i < cut; i++)
                    send_byte(8'($urandom), 1'b0, 1'($urandom), 1'b0);
            end else if (choice < 93) begin
                send_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
            end else begin
                send_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        wait_drained();
        if (mismatch_count == 0)
            $display("humidity_temp_frame_decoder_core test passed");
        else
            $display("humidity_temp_frame_decoder_core test failed");
        $finish;
    end

endmodule
